// ===== hdl/slot_set_membership_table_defines.svh =====
// ---------------------------------------------------------------------------
// Slot set membership table assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SLOT_SET_MEMBERSHIP_TABLE_DEFINES_SVH
`define SLOT_SET_MEMBERSHIP_TABLE_DEFINES_SVH

// same-cycle implication
`define SSMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSMT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ssmt_pkg.sv =====
// ---------------------------------------------------------------------------
// Slot set membership table package
// Field widths, action codes and error codes.
// ---------------------------------------------------------------------------
package ssmt_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int ACTION_W = 3;
  localparam int HANDLE_W = 4;
  localparam int ERR_W    = 3;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FIND  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DROP  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_FULL   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_HANDLE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NOTSET = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OWNED  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_FREE   = 3'd5;

endpackage

// ===== hdl/ssmt_cell.sv =====
// ---------------------------------------------------------------------------
// Slot set membership table cell
// Holds the tag of one slot; merges its tag into the passing packet.
// ---------------------------------------------------------------------------
module ssmt_cell #(
  parameter int SLOTS = ssmt_pkg::SLOTS_DEF,
  parameter int INDEX = 0,
  localparam int TW    = $clog2(SLOTS + 1),
  localparam int CW    = (TW > ssmt_pkg::HANDLE_W) ? TW : ssmt_pkg::HANDLE_W,
  localparam int PKT_W = 2 * TW + 1 + CW,
  localparam int WR_W  = 1 + CW + TW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ssmt_pkg::HANDLE_W-1:0] set_i,
  input  logic [ssmt_pkg::HANDLE_W-1:0] elem_i,
  input  logic [WR_W-1:0]              wr_i,
  input  logic                         pv_i,
  input  logic [PKT_W-1:0]             pkt_i,
  output logic                         pv_o,
  output logic [PKT_W-1:0]             pkt_o
);

  typedef struct packed {
    logic [TW-1:0] s_tag;
    logic [TW-1:0] e_tag;
    logic          free_hit;
    logic [CW-1:0] free_idx;
  } pkt_t;

  typedef struct packed {
    logic          en;
    logic [CW-1:0] idx;
    logic [TW-1:0] tag;
  } wr_t;

  pkt_t          pkt_in;
  pkt_t          pkt_nxt;
  pkt_t          pkt_r;
  wr_t           wr;
  logic [TW-1:0] tag_r;
  logic [TW-1:0] tag_nxt;
  logic          pv_r;

  assign pkt_in = pkt_i;
  assign wr     = wr_i;

  always_comb begin
    pkt_nxt = pkt_in;
    if (CW'(set_i) == CW'(INDEX)) begin
      pkt_nxt.s_tag = tag_r;
    end
    if (CW'(elem_i) == CW'(INDEX)) begin
      pkt_nxt.e_tag = tag_r;
    end
    if ((INDEX != 0) && (tag_r == '0) && !pkt_in.free_hit) begin
      pkt_nxt.free_hit = 1'b1;
      pkt_nxt.free_idx = CW'(INDEX);
    end
  end

  assign tag_nxt = (wr.en && (wr.idx == CW'(INDEX))) ? wr.tag : tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      tag_r <= tag_nxt;
      pv_r  <= pv_i;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

  assign pv_o  = pv_r;
  assign pkt_o = pkt_r;

endmodule

// ===== hdl/slot_set_membership_table.sv =====
// ---------------------------------------------------------------------------
// Slot set membership table: the lookup packet walks the row of SLOTS cells,
// one cell a cycle. One item in flight; a new item is taken only after the
// last result has gone into the output register. Synchronous reset marks
// every slot free at once; no clearing pass.
// ---------------------------------------------------------------------------
module slot_set_membership_table #(
  parameter int SLOTS = ssmt_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssmt_pkg::ACTION_W-1:0] in_action,
  input  logic [ssmt_pkg::HANDLE_W-1:0] in_set_handle,
  input  logic [ssmt_pkg::HANDLE_W-1:0] in_element_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssmt_pkg::HANDLE_W-1:0] out_result_handle,
  output logic                          out_found,
  output logic [ssmt_pkg::ERR_W-1:0]    out_error_code
);

  localparam int TW    = $clog2(SLOTS + 1);
  localparam int CW    = (TW > ssmt_pkg::HANDLE_W) ? TW : ssmt_pkg::HANDLE_W;
  localparam int HW    = ssmt_pkg::HANDLE_W;

  typedef struct packed {
    logic [TW-1:0] s_tag;
    logic [TW-1:0] e_tag;
    logic          free_hit;
    logic [CW-1:0] free_idx;
  } pkt_t;

  typedef struct packed {
    logic          en;
    logic [CW-1:0] idx;
    logic [TW-1:0] tag;
  } wr_t;

  pkt_t                        pkt_chain [0:SLOTS];
  logic                        pv_chain  [0:SLOTS];

  logic                        busy_r;
  logic                        launch_r;
  logic                        done_v_r;
  pkt_t                        done_r;
  logic [ssmt_pkg::ACTION_W-1:0] act_r;
  logic [HW-1:0]               set_r;
  logic [HW-1:0]               elem_r;

  logic                        out_valid_r;
  logic [HW-1:0]               out_res_r;
  logic                        out_found_r;
  logic [ssmt_pkg::ERR_W-1:0]  out_err_r;
  logic [HW-1:0]               out_res_nxt;
  logic                        out_found_nxt;
  logic [ssmt_pkg::ERR_W-1:0]  out_err_nxt;

  wr_t                         wr_req;
  wr_t                         wr;
  logic                        accept;
  logic                        finish;
  logic [CW-1:0]               set_w;
  logic [CW-1:0]               elem_w;
  logic [TW-1:0]               unowned;
  logic                        s_ok;
  logic                        e_ok;
  logic [ssmt_pkg::ERR_W-1:0]  chk_err;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign finish   = done_v_r && (!out_valid_r || !out_stall);

  assign pkt_chain[0] = '0;
  assign pv_chain[0]  = launch_r;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      ssmt_cell #(
        .SLOTS (SLOTS),
        .INDEX (g)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .set_i  (set_r),
        .elem_i (elem_r),
        .wr_i   (wr),
        .pv_i   (pv_chain[g]),
        .pkt_i  (pkt_chain[g]),
        .pv_o   (pv_chain[g+1]),
        .pkt_o  (pkt_chain[g+1])
      );
    end
  endgenerate

  assign set_w   = CW'(set_r);
  assign elem_w  = CW'(elem_r);
  assign unowned = TW'(SLOTS);
  assign s_ok    = (set_r != '0) && (set_w < CW'(SLOTS));
  assign e_ok    = (elem_r != '0) && (elem_w < CW'(SLOTS));

  always_comb begin
    if (!s_ok) begin
      chk_err = ssmt_pkg::ERR_HANDLE;
    end else if (done_r.s_tag != unowned) begin
      chk_err = ssmt_pkg::ERR_NOTSET;
    end else if (!e_ok) begin
      chk_err = ssmt_pkg::ERR_HANDLE;
    end else begin
      chk_err = ssmt_pkg::ERR_OK;
    end
  end

  always_comb begin
    out_res_nxt   = '0;
    out_found_nxt = 1'b0;
    out_err_nxt   = ssmt_pkg::ERR_OK;
    wr_req        = '0;
    case (act_r)
      ssmt_pkg::ACT_ALLOC: begin
        if (done_r.free_hit) begin
          out_res_nxt = done_r.free_idx[HW-1:0];
          wr_req      = '{en: 1'b1, idx: done_r.free_idx, tag: unowned};
        end else begin
          out_err_nxt = ssmt_pkg::ERR_FULL;
        end
      end
      ssmt_pkg::ACT_FREE: begin
        if (elem_r != '0) begin
          if (elem_w < CW'(SLOTS)) begin
            wr_req = '{en: 1'b1, idx: elem_w, tag: '0};
          end else begin
            out_err_nxt = ssmt_pkg::ERR_HANDLE;
          end
        end
      end
      ssmt_pkg::ACT_ADD: begin
        out_err_nxt = chk_err;
        if (chk_err == ssmt_pkg::ERR_OK) begin
          if (done_r.e_tag == unowned) begin
            out_res_nxt = elem_r;
            wr_req      = '{en: 1'b1, idx: elem_w, tag: TW'(set_w)};
          end else if (CW'(done_r.e_tag) == set_w) begin
            out_res_nxt = elem_r;
          end else begin
            out_err_nxt = ssmt_pkg::ERR_OWNED;
          end
        end
      end
      ssmt_pkg::ACT_FIND, ssmt_pkg::ACT_DROP: begin
        out_err_nxt = chk_err;
        if (chk_err == ssmt_pkg::ERR_OK) begin
          if (done_r.e_tag == '0) begin
            out_err_nxt = ssmt_pkg::ERR_FREE;
          end else if (CW'(done_r.e_tag) == set_w) begin
            out_found_nxt = 1'b1;
            out_res_nxt   = elem_r;
            if (act_r == ssmt_pkg::ACT_DROP) begin
              wr_req = '{en: 1'b1, idx: elem_w, tag: unowned};
            end
          end
        end
      end
      default: begin
        out_err_nxt = ssmt_pkg::ERR_OK;
      end
    endcase
  end

  always_comb begin
    wr    = wr_req;
    wr.en = wr_req.en && finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      done_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (pv_chain[SLOTS]) begin
        done_v_r <= 1'b1;
      end else if (finish) begin
        done_v_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      set_r  <= in_set_handle;
      elem_r <= in_element_handle;
    end
    if (pv_chain[SLOTS]) begin
      done_r <= pkt_chain[SLOTS];
    end
    if (finish) begin
      out_res_r   <= out_res_nxt;
      out_found_r <= out_found_nxt;
      out_err_r   <= out_err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_handle = out_res_r;
  assign out_found         = out_found_r;
  assign out_error_code    = out_err_r;

endmodule

// ===== hdl/ssmt_checker.sv =====
// ---------------------------------------------------------------------------
// Slot set membership table checker
// Port-level properties of the table, bound to the top level.
// ---------------------------------------------------------------------------
`include "slot_set_membership_table_defines.svh"

module ssmt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ssmt_pkg::HANDLE_W-1:0] out_result_handle,
  input logic                          out_found,
  input logic [ssmt_pkg::ERR_W-1:0]    out_error_code
);

  `SSMT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_result_handle) && $stable(out_found)
                   && $stable(out_error_code),
                   "result item changed while stalled")

  `SSMT_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall,
                   "second item taken while one is in flight")

  `SSMT_ASSERT_NOW(a_err_clean,
                   out_valid && (out_error_code != ssmt_pkg::ERR_OK),
                   (out_result_handle == '0) && !out_found,
                   "error item carries a handle or found")

  `SSMT_ASSERT_NOW(a_found_ok, out_valid && out_found,
                   (out_error_code == ssmt_pkg::ERR_OK) && (out_result_handle != '0),
                   "found item without a handle or with an error")

endmodule

bind slot_set_membership_table ssmt_checker u_ssmt_checker (.*);

// ===== test/tb_slot_set_membership_table.sv =====
// ---------------------------------------------------------------------------
// Slot set membership table testbench
// Drives allocate, free, add, find, drop and unused-code items through the
// valid/stall channels with random gaps on both sides. A shadow copy of the
// slot tags predicts every reply; each is checked field by field in order.
// ---------------------------------------------------------------------------
module tb_slot_set_membership_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ssmt_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 317;

  localparam logic [4:0] TAG_FREE    = 5'd0;
  localparam logic [4:0] TAG_UNOWNED = 5'(SLOTS);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                found;
    logic [ERR_W-1:0]    err;
  } reply_t;

  typedef enum int {PICK_LIVE, PICK_SET, PICK_MEMBER} pick_t;

  class slot_tag_shadow;
    logic [4:0] tag [SLOTS];
    reply_t     owed [$];
    int         mismatches;
    int         replies;
    int         refusals;
    int         hits;
    int         per_action [8];

    function new();
      foreach (tag[i]) tag[i] = TAG_FREE;
      foreach (per_action[i]) per_action[i] = 0;
      mismatches = 0;
      replies    = 0;
      refusals   = 0;
      hits       = 0;
    endfunction

    function logic [ERR_W-1:0] pair_error(logic [HANDLE_W-1:0] s, logic [HANDLE_W-1:0] e);
      if (s == 0 || s >= SLOTS) return ERR_HANDLE;
      if (tag[s] != TAG_UNOWNED) return ERR_NOTSET;
      if (e == 0 || e >= SLOTS) return ERR_HANDLE;
      return ERR_OK;
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [HANDLE_W-1:0] s,
                               logic [HANDLE_W-1:0] e);
      reply_t r;
      bit     placed;
      r = '0;
      placed = 0;
      per_action[act]++;
      case (act)
        ACT_ALLOC: begin
          r.err = ERR_FULL;
          for (int i = 1; i < SLOTS; i++) begin
            if (!placed && tag[i] == TAG_FREE) begin
              tag[i]   = TAG_UNOWNED;
              r.handle = HANDLE_W'(i);
              r.err    = ERR_OK;
              placed   = 1;
            end
          end
        end
        ACT_FREE: begin
          if (e != 0) begin
            if (e < SLOTS) tag[e] = TAG_FREE;
            else r.err = ERR_HANDLE;
          end
        end
        ACT_ADD: begin
          r.err = pair_error(s, e);
          if (r.err == ERR_OK) begin
            if (tag[e] == TAG_UNOWNED) begin
              tag[e]   = {1'b0, s};
              r.handle = e;
            end else if (tag[e] == {1'b0, s}) begin
              r.handle = e;
            end else begin
              r.err = ERR_OWNED;
            end
          end
        end
        ACT_FIND, ACT_DROP: begin
          r.err = pair_error(s, e);
          if (r.err == ERR_OK) begin
            if (tag[e] == TAG_FREE) begin
              r.err = ERR_FREE;
            end else if (tag[e] == {1'b0, s}) begin
              r.found  = 1'b1;
              r.handle = e;
              if (act == ACT_DROP) tag[e] = TAG_UNOWNED;
            end
          end
        end
        default: ;
      endcase
      if (r.err == ERR_FULL) refusals++;
      if (r.found) hits++;
      owed.push_back(r);
    endfunction

    function void check_reply(logic [HANDLE_W-1:0] handle, logic found, logic [ERR_W-1:0] err);
      reply_t x;
      replies++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected reply handle=%0d found=%0d error=%0d",
                 $time, handle, found, err);
        mismatches++;
        return;
      end
      x = owed.pop_front();
      if (handle !== x.handle) begin
        $display("%0t: result_handle expected %0d actual %0d", $time, x.handle, handle);
        mismatches++;
      end
      if (found !== x.found) begin
        $display("%0t: found expected %0d actual %0d", $time, x.found, found);
        mismatches++;
      end
      if (err !== x.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, x.err, err);
        mismatches++;
      end
    endfunction

    function logic [HANDLE_W-1:0] pick_slot(pick_t mode, logic [HANDLE_W-1:0] owner);
      logic [HANDLE_W-1:0] cands [$];
      for (int i = 1; i < SLOTS; i++) begin
        if ((mode == PICK_LIVE && tag[i] != TAG_FREE) ||
            (mode == PICK_SET && tag[i] == TAG_UNOWNED) ||
            (mode == PICK_MEMBER && tag[i] == {1'b0, owner}))
          cands.push_back(HANDLE_W'(i));
      end
      if (cands.size() == 0) return HANDLE_W'($urandom_range(1, SLOTS - 1));
      return cands[$urandom_range(0, cands.size() - 1)];
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action;
  logic [HANDLE_W-1:0] in_set_handle;
  logic [HANDLE_W-1:0] in_element_handle;
  logic                out_valid;
  logic                out_stall;
  logic [HANDLE_W-1:0] out_result_handle;
  logic                out_found;
  logic [ERR_W-1:0]    out_error_code;

  slot_tag_shadow shadow;
  bit             quiet;
  int             idle_cycles;

  slot_set_membership_table #(.SLOTS(SLOTS)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_set_handle     (in_set_handle),
    .in_element_handle (in_element_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_handle (out_result_handle),
    .out_found         (out_found),
    .out_error_code    (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        shadow.check_reply(out_result_handle, out_found, out_error_code);
      if (in_valid && !in_stall)
        shadow.note_request(in_action, in_set_handle, in_element_handle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reply side: hold stall for a drawn number of cycles, then take one item
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [ACTION_W-1:0] a, input logic [HANDLE_W-1:0] s,
                              input logic [HANDLE_W-1:0] e);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= a;
    in_set_handle     <= s;
    in_element_handle <= e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (shadow.owed.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    for (int i = 0; i < SLOTS; i++) send_request(ACT_ALLOC, 4'd0, 4'd0);
    send_request(ACT_ADD, 4'd1, 4'd2);
    send_request(ACT_ADD, 4'd1, 4'd2);
    send_request(ACT_FIND, 4'd1, 4'd2);
    send_request(ACT_ADD, 4'd2, 4'd3);
    send_request(ACT_ADD, 4'd0, 4'd3);
    send_request(ACT_ADD, 4'd1, 4'd0);
    send_request(ACT_FREE, 4'd0, 4'd15);
    send_request(ACT_FIND, 4'd1, 4'd15);
    send_request(ACT_ADD, 4'd1, 4'd15);
    send_request(ACT_FIND, 4'd1, 4'd3);
    send_request(ACT_DROP, 4'd1, 4'd2);
    send_request(ACT_DROP, 4'd1, 4'd2);
    send_request(ACT_ADD, 4'd3, 4'd3);
    send_request(ACT_ADD, 4'd1, 4'd3);
    send_request(ACT_ADD, 4'd3, 4'd4);
    send_request(ACT_FREE, 4'd15, 4'd0);
    send_request(ACT_FREE, 4'd0, 4'd15);
    send_request(3'd7, 4'd15, 4'd15);
    send_request(3'd5, 4'd0, 4'd0);
  endtask

  task automatic random_request();
    int                  k;
    int                  m;
    logic [ACTION_W-1:0] a;
    logic [HANDLE_W-1:0] s;
    logic [HANDLE_W-1:0] e;
    k = $urandom_range(0, 99);
    if (k < 18) a = ACT_ALLOC;
    else if (k < 33) a = ACT_FREE;
    else if (k < 55) a = ACT_ADD;
    else if (k < 75) a = ACT_FIND;
    else if (k < 94) a = ACT_DROP;
    else a = ACTION_W'($urandom_range(0, 7));
    s = ($urandom_range(0, 9) < 8) ? shadow.pick_slot(PICK_SET, 4'd0)
                                   : HANDLE_W'($urandom_range(0, 15));
    m = $urandom_range(0, 9);
    if (m < 2) e = HANDLE_W'($urandom_range(0, 15));
    else if ((a == ACT_FIND || a == ACT_DROP) && m < 7) e = shadow.pick_slot(PICK_MEMBER, s);
    else if (a == ACT_ADD && m < 6) e = shadow.pick_slot(PICK_SET, 4'd0);
    else e = shadow.pick_slot(PICK_LIVE, 4'd0);
    send_request(a, s, e);
  endtask

  initial begin
    shadow            = new();
    quiet             = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = '0;
    in_set_handle     = '0;
    in_element_handle = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 1 || p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      hold_until_drained();
    end
    quiet = 1'b0;

    while (shadow.owed.size() != 0) @(negedge clk);
    repeat (SLOTS + 5) @(negedge clk);

    $display("items: alloc %0d, free %0d, add %0d, find %0d, drop %0d, unused codes %0d",
             shadow.per_action[ACT_ALLOC], shadow.per_action[ACT_FREE],
             shadow.per_action[ACT_ADD], shadow.per_action[ACT_FIND],
             shadow.per_action[ACT_DROP],
             shadow.per_action[5] + shadow.per_action[6] + shadow.per_action[7]);
    $display("replies %0d, full-table refusals %0d, members located %0d, mismatches %0d",
             shadow.replies, shadow.refusals, shadow.hits, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
